>>> rtl/assert_macros.svh
// Assertion macros shared by the extended GCD unit modules.
// Depends on nothing; compiling with ASSERT_OFF defined removes every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/xgcd_pkg.sv
// Shared widths, controller states and command/status types for the extended GCD unit.
// Used by xgcd_ctrl, xgcd_dp and extended_gcd_unit; depends on nothing.
package xgcd_pkg;

  localparam int DW        = 32;
  localparam int CW        = DW + 1;
  localparam int DIV_STEPS = DW;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DINIT,
    ST_DIV,
    ST_CHK,
    ST_MULS,
    ST_MULT,
    ST_UPD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load_in;
    logic div_init;
    logic div_step;
    logic mul_s;
    logic mul_t;
    logic upd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic zero_op;
    logic rem_zero;
  } status_t;

endpackage

>>> rtl/xgcd_ctrl.sv
// Controller state machine of the extended GCD unit: sequences load, division,
// coefficient update and result hand-off. Depends on xgcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xgcd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  xgcd_pkg::status_t status,
  output xgcd_pkg::cmd_t    cmd
);
  import xgcd_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_START;
        end
      end
      ST_START: begin
        state_nxt = status.zero_op ? ST_FIN : ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        state_nxt = status.rem_zero ? ST_FIN : ST_MULS;
      end
      ST_MULS: begin
        cmd.mul_s = 1'b1;
        state_nxt = ST_MULT;
      end
      ST_MULT: begin
        cmd.mul_t = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_DINIT;
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  `ASSERT_IMPLY(a_load_out_free, clk, rst_n, cmd.load_out, !out_valid_r || out_tready, "result word overwritten before it was taken")
  `ASSERT_NEXT(a_accept_starts, clk, rst_n, in_tvalid && in_tready, state_r == ST_START, "accepted word did not start a run")

endmodule

>>> rtl/xgcd_dp.sv
// Datapath of the extended GCD unit: operand and coefficient registers, a
// one-bit-per-cycle restoring divider, a shared multiplier and the result register.
// Depends on xgcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xgcd_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [xgcd_pkg::DW-1:0]   operand_a,
  input  logic [xgcd_pkg::DW-1:0]   operand_b,
  input  xgcd_pkg::cmd_t            cmd,
  output xgcd_pkg::status_t         status,
  output logic [xgcd_pkg::DW-1:0]   gcd_value,
  output logic [xgcd_pkg::DW-1:0]   coef_a,
  output logic [xgcd_pkg::DW-1:0]   coef_b,
  output logic                      domain_error
);
  import xgcd_pkg::*;

  logic [DW-1:0]          a_r, b_r;
  logic signed [CW-1:0]   s_r, t_r, sp_r, tp_r, prod_r;
  logic [DW-1:0]          rem_r, quo_r;
  logic [DW-1:0]          gcd_r, coef_a_r, coef_b_r;
  logic                   err_r;

  logic [DW-1:0]          a_abs, b_abs, r_signed;
  logic [DW:0]            trial;
  logic signed [CW-1:0]   q_signed, mul_op;
  logic signed [2*CW-1:0] mul_res;
  logic                   b_neg;

  assign a_abs    = a_r[DW-1] ? (~a_r + 1'b1) : a_r;
  assign b_abs    = b_r[DW-1] ? (~b_r + 1'b1) : b_r;
  assign trial    = {rem_r, quo_r[DW-1]} - {1'b0, b_abs};
  assign r_signed = a_r[DW-1] ? (~rem_r + 1'b1) : rem_r;
  assign q_signed = (a_r[DW-1] ^ b_r[DW-1]) ? -$signed({1'b0, quo_r})
                                            : $signed({1'b0, quo_r});
  assign mul_op   = cmd.mul_s ? s_r : t_r;
  assign mul_res  = mul_op * q_signed;
  assign b_neg    = b_r[DW-1];

  assign status.zero_op  = (a_r == '0) || (b_r == '0);
  assign status.rem_zero = (rem_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_r  <= operand_a;
      b_r  <= operand_b;
      s_r  <= '0;
      t_r  <= CW'(1);
      sp_r <= CW'(1);
      tp_r <= '0;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      quo_r <= a_abs;
    end
    if (cmd.div_step) begin
      if (!trial[DW]) begin
        rem_r <= trial[DW-1:0];
      end else begin
        rem_r <= {rem_r[DW-2:0], quo_r[DW-1]};
      end
      quo_r <= {quo_r[DW-2:0], ~trial[DW]};
    end
    if (cmd.mul_s) begin
      prod_r <= mul_res[CW-1:0];
    end
    if (cmd.mul_t) begin
      s_r    <= sp_r - prod_r;
      sp_r   <= s_r;
      prod_r <= mul_res[CW-1:0];
    end
    if (cmd.upd) begin
      t_r  <= tp_r - prod_r;
      tp_r <= t_r;
      a_r  <= b_r;
      b_r  <= r_signed;
    end
    if (cmd.load_out) begin
      if (status.zero_op) begin
        gcd_r    <= '0;
        coef_a_r <= '0;
        coef_b_r <= '0;
        err_r    <= 1'b1;
      end else begin
        gcd_r    <= b_abs;
        coef_a_r <= b_neg ? (~s_r[DW-1:0] + 1'b1) : s_r[DW-1:0];
        coef_b_r <= b_neg ? (~t_r[DW-1:0] + 1'b1) : t_r[DW-1:0];
        err_r    <= 1'b0;
      end
    end
  end

  assign gcd_value    = gcd_r;
  assign coef_a       = coef_a_r;
  assign coef_b       = coef_b_r;
  assign domain_error = err_r;

  `ASSERT_IMPLY(a_divisor_nonzero, clk, rst_n, cmd.div_step, b_r != '0, "division started with a zero divisor")
  `ASSERT_NEXT(a_rem_below_div, clk, rst_n, cmd.div_step, rem_r < b_abs, "partial remainder reached the divisor")

endmodule

>>> rtl/extended_gcd_unit.sv
// Extended GCD unit: gcd and Bezout coefficients of two signed 32-bit operands.
// Instantiates xgcd_ctrl and xgcd_dp; depends on xgcd_pkg.
//
// Each input word runs the Euclidean loop with truncating division; the result word
// carries the positive gcd and coefficients with a*coef_a + b*coef_b = gcd, or zeros
// and a set domain_error flag when either operand is zero. One word is worked on at a
// time. A word goes from ST_START straight to ST_FIN when an operand is zero; else each
// loop pass runs ST_DINIT, ST_DIV and ST_CHK, plus ST_MULS, ST_MULT and ST_UPD while
// the remainder is nonzero. In ST_FIN the result moves into the output register only
// once that register is empty or its result is being taken. Each pass is dominated by
// the restoring divider, which resolves one quotient bit per cycle, followed by the
// shared multiplier in ST_MULS and ST_MULT and by ST_UPD for the coefficient update.
// A new word is accepted as soon as the previous result has moved into the output register.
module extended_gcd_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // operand_a [31:0], operand_b [63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // gcd_value [31:0], coef_a [63:32], coef_b [95:64]
  output logic [0:0]  out_tuser   // domain_error [0]
);
  import xgcd_pkg::*;

  cmd_t          cmd;
  status_t       status;
  logic [DW-1:0] gcd_value, coef_a, coef_b;
  logic          domain_error;

  xgcd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  xgcd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .operand_a    (in_tdata[DW-1:0]),
    .operand_b    (in_tdata[2*DW-1:DW]),
    .cmd          (cmd),
    .status       (status),
    .gcd_value    (gcd_value),
    .coef_a       (coef_a),
    .coef_b       (coef_b),
    .domain_error (domain_error)
  );

  assign out_tdata = {coef_b, coef_a, gcd_value};
  assign out_tuser = domain_error;

endmodule
